@@ design/alp_pkg.sv @@
// shared types, constants and helpers of the linked-list node pool
package alp_pkg;

  // pool geometry
  localparam int NODES      = 32;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = $clog2(NODES);
  localparam int LINK_W     = IDX_W + 1;
  localparam int PTR_W      = 5;

  // nil link: the value NODES, its top bit marks an empty link
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NO_SUCC = 2'd3;

  // input word
  typedef struct packed {
    logic [1:0]                   req_type;
    logic                         at_head;
    logic [PTR_W-1:0]             pred_index;
    logic signed [DATA_WIDTH-1:0] item;
  } alp_req_t;

  // result word
  typedef struct packed {
    logic [1:0]                   status;
    logic [PTR_W-1:0]             node_index;
    logic signed [DATA_WIDTH-1:0] node_data;
    logic [PTR_W-1:0]             node_next;
    logic                         next_is_nil;
    logic [PTR_W-1:0]             head_index;
    logic                         list_empty;
    logic                         pool_full;
  } alp_res_t;

  // link value of an entry that was never written
  function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] a);
    logic [LINK_W-1:0] r;
    if (LINK_W'(a) == LINK_W'(NODES - 1)) begin
      r = NIL;
    end else begin
      r = LINK_W'(a) + LINK_W'(1);
    end
    return r;
  endfunction

endpackage

@@ design/alp_ram.sv @@
// generic single-write, single-read ram with registered read data
module alp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/array_linked_list_pool.sv @@
// linked-list node pool with free list, links and data in two rams
//
//  channel   signals                      direction  handshake
//  request   start, busy, request         in         taken when start && !busy
//  result    done, result                 out        one-cycle strobe on done
//
// insert at head, delete at head, read and a delete that finds no successor
// finish in S_R1 after the first link read; insert after a node and delete
// after a node go on through S_R2 and S_W2; rejected requests finish in S_IDLE.
// the order is set by the single read port of the link ram: each dependent
// link read takes a state of its own, and a second link write one more.
// reset sets the state and pool registers at once; per-entry valid bits stand
// in for the initial ram contents, so no clearing pass is needed.
// busy is low again in the cycle the result is shown; results cannot be stalled.
module array_linked_list_pool import alp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  alp_req_t request,
  output logic     done,
  output alp_res_t result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_R1,
    S_R2,
    S_W2
  } state_t;

  state_t state, state_next;

  logic [LINK_W-1:0] list_head, list_head_next;
  logic [LINK_W-1:0] free_head, free_head_next;
  logic [IDX_W-1:0]  tmp, tmp_next;
  alp_req_t          rq;

  logic [NODES-1:0]  link_valid;
  logic [NODES-1:0]  data_valid;

  // ram ports
  logic [IDX_W-1:0]      lnk_raddr, lnk_raddr_q;
  logic                  lnk_we;
  logic [IDX_W-1:0]      lnk_waddr;
  logic [LINK_W-1:0]     lnk_wdata, lnk_q, lnk_rd;
  logic                  lnk_vld_q;
  logic                  dat_we;
  logic [IDX_W-1:0]      dat_waddr;
  logic [DATA_WIDTH-1:0] dat_wdata, dat_q, dat_rd;
  logic                  dat_vld_q;

  // finishing step
  logic                  fin;
  logic [1:0]            f_status;
  logic [IDX_W-1:0]      f_idx;
  logic                  f_read;

  logic                  pred_ok;
  logic [IDX_W-1:0]      pred_in;

  alp_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_link (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (lnk_raddr),
    .rdata (lnk_q)
  );

  alp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_data (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .raddr (lnk_raddr),
    .rdata (dat_q)
  );

  assign busy = (state != S_IDLE);

  // never-written entries read as their reset values
  assign lnk_rd = lnk_vld_q ? lnk_q : reset_link(lnk_raddr_q);
  assign dat_rd = dat_vld_q ? dat_q : {DATA_WIDTH{1'b1}};

  assign pred_ok = (32'(request.pred_index) < NODES);
  assign pred_in = IDX_W'(request.pred_index);

  // sequencer: reads, then write-back of links and data
  always_comb begin
    state_next     = state;
    list_head_next = list_head;
    free_head_next = free_head;
    tmp_next       = tmp;
    lnk_raddr      = lnk_raddr_q;
    lnk_we         = 1'b0;
    lnk_waddr      = tmp;
    lnk_wdata      = free_head;
    dat_we         = 1'b0;
    dat_waddr      = tmp;
    dat_wdata      = {DATA_WIDTH{1'b1}};
    fin            = 1'b0;
    f_status       = ST_OK;
    f_idx          = tmp;
    f_read         = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (request.req_type)
            REQ_INSERT: begin
              if (free_head == NIL) begin
                fin      = 1'b1;
                f_status = ST_FULL;
              end else if (!request.at_head && !pred_ok) begin
                fin      = 1'b1;
                f_status = ST_NO_SUCC;
              end else begin
                lnk_raddr  = free_head[IDX_W-1:0];
                tmp_next   = free_head[IDX_W-1:0];
                state_next = S_R1;
              end
            end
            REQ_DELETE: begin
              if (list_head == NIL) begin
                fin      = 1'b1;
                f_status = ST_EMPTY;
              end else if (request.at_head) begin
                lnk_raddr  = list_head[IDX_W-1:0];
                tmp_next   = list_head[IDX_W-1:0];
                state_next = S_R1;
              end else if (!pred_ok) begin
                fin      = 1'b1;
                f_status = ST_NO_SUCC;
              end else begin
                lnk_raddr  = pred_in;
                state_next = S_R1;
              end
            end
            REQ_READ: begin
              if (request.at_head) begin
                if (list_head == NIL) begin
                  fin      = 1'b1;
                  f_status = ST_EMPTY;
                end else begin
                  lnk_raddr  = list_head[IDX_W-1:0];
                  state_next = S_R1;
                end
              end else if (!pred_ok) begin
                fin      = 1'b1;
                f_status = ST_NO_SUCC;
              end else begin
                lnk_raddr  = pred_in;
                state_next = S_R1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_R1: begin
        case (rq.req_type)
          REQ_INSERT: begin
            free_head_next = lnk_rd;
            if (rq.at_head) begin
              lnk_we         = 1'b1;
              lnk_wdata      = list_head;
              dat_we         = 1'b1;
              dat_wdata      = rq.item;
              list_head_next = LINK_W'(tmp);
              fin            = 1'b1;
              state_next     = S_IDLE;
            end else begin
              lnk_raddr  = IDX_W'(rq.pred_index);
              state_next = S_R2;
            end
          end
          REQ_DELETE: begin
            if (rq.at_head) begin
              lnk_we         = 1'b1;
              dat_we         = 1'b1;
              list_head_next = lnk_rd;
              free_head_next = LINK_W'(tmp);
              fin            = 1'b1;
              state_next     = S_IDLE;
            end else if (lnk_rd == NIL) begin
              f_status   = ST_NO_SUCC;
              fin        = 1'b1;
              state_next = S_IDLE;
            end else begin
              tmp_next   = lnk_rd[IDX_W-1:0];
              lnk_raddr  = lnk_rd[IDX_W-1:0];
              state_next = S_R2;
            end
          end
          default: begin
            f_read     = 1'b1;
            f_idx      = lnk_raddr_q;
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_R2: begin
        if (rq.req_type == REQ_INSERT) begin
          // new node takes the predecessor's old link
          lnk_we    = 1'b1;
          lnk_wdata = lnk_rd;
          dat_we    = 1'b1;
          dat_wdata = rq.item;
        end else begin
          // predecessor skips the removed node
          lnk_we    = 1'b1;
          lnk_waddr = IDX_W'(rq.pred_index);
          lnk_wdata = lnk_rd;
          dat_we    = 1'b1;
        end
        state_next = S_W2;
      end
      S_W2: begin
        if (rq.req_type == REQ_INSERT) begin
          lnk_we    = 1'b1;
          lnk_waddr = IDX_W'(rq.pred_index);
          lnk_wdata = LINK_W'(tmp);
        end else begin
          lnk_we         = 1'b1;
          lnk_wdata      = free_head;
          free_head_next = LINK_W'(tmp);
        end
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, pool registers, valid bits and the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      list_head  <= NIL;
      free_head  <= '0;
      link_valid <= '0;
      data_valid <= '0;
      done       <= 1'b0;
    end else begin
      state     <= state_next;
      list_head <= list_head_next;
      free_head <= free_head_next;
      done      <= fin;
      if (lnk_we) begin
        link_valid[lnk_waddr] <= 1'b1;
      end
      if (dat_we) begin
        data_valid[dat_waddr] <= 1'b1;
      end
    end
    if (state == S_IDLE && start) begin
      rq <= request;
    end
    tmp         <= tmp_next;
    lnk_raddr_q <= lnk_raddr;
    lnk_vld_q   <= link_valid[lnk_raddr];
    dat_vld_q   <= data_valid[lnk_raddr];
    if (fin) begin
      result.status      <= f_status;
      result.node_index  <= (f_status == ST_OK && (state != S_IDLE)) ? PTR_W'(f_idx) : '0;
      result.node_data   <= f_read ? dat_rd : '0;
      result.node_next   <= (f_read && lnk_rd != NIL) ? PTR_W'(lnk_rd[IDX_W-1:0]) : '0;
      result.next_is_nil <= f_read && (lnk_rd == NIL);
      result.head_index  <= (list_head_next == NIL) ? '0
                                                    : PTR_W'(list_head_next[IDX_W-1:0]);
      result.list_empty  <= (list_head_next == NIL);
      result.pool_full   <= (free_head_next == NIL);
    end
  end

  // a result follows an accepted word or a working cycle
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(state != S_IDLE)))
    else $error("result without request");

  // rams are written only during a request
  assert property (@(posedge clk) disable iff (rst)
    (lnk_we || dat_we) |-> (state != S_IDLE))
    else $error("ram write while idle");

  // second link write always follows the dependent read
  assert property (@(posedge clk) disable iff (rst)
    (state == S_W2) |-> ($past(state) == S_R2))
    else $error("second write out of order");

  // a delete after a node only starts its second read on a real successor
  assert property (@(posedge clk) disable iff (rst)
    (state == S_R2 && rq.req_type == REQ_DELETE) |-> $past(lnk_rd != NIL))
    else $error("delete walked a nil link");

endmodule

@@ sim/tb_top.sv @@
// testbench for the linked-list node pool: directed and random requests checked by a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import alp_pkg::*;

  // request code with no operation behind it
  localparam logic [1:0] REQ_NOP = 2'd3;
  // data left in a node when it is released
  localparam logic signed [DATA_WIDTH-1:0] BLANK_DATA = '1;
  localparam int STALL_LIMIT  = 200;
  localparam int DRAIN_CYCLES = 8;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  alp_req_t request = '0;
  logic     busy;
  logic     done;
  alp_res_t result;

  // predicted pool contents
  logic [LINK_W-1:0]            link_mem [NODES];
  logic signed [DATA_WIDTH-1:0] data_mem [NODES];
  logic [LINK_W-1:0]            list_top;
  logic [LINK_W-1:0]            free_top;

  alp_res_t awaited_words[$];
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  bit       idle_enable = 1'b1;

  array_linked_list_pool dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pool state right after reset: every node free, chained in index order
  function automatic void reset_pool_model();
    for (int i = 0; i < NODES; i++) begin
      link_mem[i] = (i == NODES - 1) ? NIL : LINK_W'(i + 1);
      data_mem[i] = BLANK_DATA;
    end
    list_top = NIL;
    free_top = '0;
  endfunction

  // apply one request to the predicted pool and return the word it yields
  function automatic alp_res_t pool_apply(input alp_req_t w);
    alp_res_t          r;
    logic [LINK_W-1:0] node;
    logic [IDX_W-1:0]  n;
    logic [IDX_W-1:0]  p;
    r = '0;
    p = w.pred_index[IDX_W-1:0];
    case (w.req_type)
      REQ_INSERT: begin
        if (free_top == NIL) begin
          r.status = ST_FULL;
        end else if (!w.at_head && int'(w.pred_index) >= NODES) begin
          r.status = ST_NO_SUCC;
        end else begin
          n = free_top[IDX_W-1:0];
          free_top = link_mem[n];
          data_mem[n] = w.item;
          if (w.at_head) begin
            link_mem[n] = list_top;
            list_top = LINK_W'(n);
          end else begin
            link_mem[n] = link_mem[p];
            link_mem[p] = LINK_W'(n);
          end
          r.node_index = PTR_W'(n);
        end
      end
      REQ_DELETE: begin
        if (list_top == NIL) begin
          r.status = ST_EMPTY;
        end else if (w.at_head) begin
          n = list_top[IDX_W-1:0];
          list_top = link_mem[n];
          link_mem[n] = free_top;
          data_mem[n] = BLANK_DATA;
          free_top = LINK_W'(n);
          r.node_index = PTR_W'(n);
        end else if (int'(w.pred_index) >= NODES || link_mem[p] == NIL) begin
          r.status = ST_NO_SUCC;
        end else begin
          n = link_mem[p][IDX_W-1:0];
          link_mem[p] = link_mem[n];
          link_mem[n] = free_top;
          data_mem[n] = BLANK_DATA;
          free_top = LINK_W'(n);
          r.node_index = PTR_W'(n);
        end
      end
      REQ_READ: begin
        node = LINK_W'(w.pred_index);
        if (w.at_head) begin
          if (list_top == NIL) r.status = ST_EMPTY;
          node = list_top;
        end else if (int'(w.pred_index) >= NODES) begin
          r.status = ST_NO_SUCC;
        end
        if (r.status == ST_OK) begin
          n = node[IDX_W-1:0];
          r.node_index = PTR_W'(n);
          r.node_data = data_mem[n];
          if (link_mem[n] == NIL) begin
            r.next_is_nil = 1'b1;
          end else begin
            r.node_next = link_mem[n][PTR_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    // list and pool summary after the step
    r.head_index = (list_top == NIL) ? '0 : list_top[PTR_W-1:0];
    r.list_empty = (list_top == NIL);
    r.pool_full  = (free_top == NIL);
    return r;
  endfunction

  // random node currently on the list; any node when the list is empty
  function automatic logic [PTR_W-1:0] pick_list_node();
    logic [LINK_W-1:0] walk;
    int                len;
    int                k;
    len = 0;
    walk = list_top;
    while (walk != NIL && len < NODES) begin
      len++;
      walk = link_mem[walk[IDX_W-1:0]];
    end
    if (len == 0) return PTR_W'($urandom_range(0, NODES - 1));
    k = $urandom_range(0, len - 1);
    walk = list_top;
    repeat (k) walk = link_mem[walk[IDX_W-1:0]];
    return walk[PTR_W-1:0];
  endfunction

  function automatic alp_req_t make_req(input logic [1:0] op, input logic head,
                                        input logic [PTR_W-1:0] idx,
                                        input logic signed [DATA_WIDTH-1:0] val);
    alp_req_t w;
    w.req_type   = op;
    w.at_head    = head;
    w.pred_index = idx;
    w.item       = val;
    return w;
  endfunction

  // random request; stray ones may link through nodes that are not on the list
  function automatic alp_req_t rand_request(input bit stray, input bit grow);
    int           roll;
    logic [1:0]   op;
    logic         head;
    logic [PTR_W-1:0] idx;
    roll = $urandom_range(0, 99);
    if (grow) begin
      op = (roll < 55) ? REQ_INSERT : (roll < 80) ? REQ_DELETE : (roll < 96) ? REQ_READ : REQ_NOP;
    end else begin
      op = (roll < 25) ? REQ_INSERT : (roll < 80) ? REQ_DELETE : (roll < 96) ? REQ_READ : REQ_NOP;
    end
    head = 1'($urandom_range(0, 1));
    if (stray || op == REQ_NOP || (op == REQ_READ && $urandom_range(0, 3) == 0)) begin
      idx = PTR_W'($urandom_range(0, 31));
    end else begin
      idx = pick_list_node();
    end
    // keep well-formed inserts from linking after a free node
    if (!stray && op == REQ_INSERT && list_top == NIL) head = 1'b1;
    return make_req(op, head, idx, DATA_WIDTH'($urandom()));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  // send one word, with an optional idle burst ahead of it
  task automatic send_word(input alp_req_t w);
    int gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_words.push_back(pool_apply(w));
  endtask

  // hold off until every predicted word has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
  endtask

  // empty-list cases, reset contents, head and mid-list insert, delete and read
  task automatic test_directed();
    send_word(make_req(REQ_READ,   1'b1, 5'd0,  16'sd0));
    send_word(make_req(REQ_DELETE, 1'b1, 5'd0,  16'sd0));
    send_word(make_req(REQ_DELETE, 1'b0, 5'd5,  16'sd0));
    send_word(make_req(REQ_READ,   1'b0, 5'd31, 16'sd0));
    send_word(make_req(REQ_READ,   1'b0, 5'd0,  16'sd0));
    send_word(make_req(REQ_NOP,    1'b1, 5'd31, 16'h7fff));
    send_word(make_req(REQ_INSERT, 1'b1, 5'd0,  16'sh7fff));
    send_word(make_req(REQ_INSERT, 1'b1, 5'd31, 16'sh8000));
    send_word(make_req(REQ_INSERT, 1'b0, 5'd1,  16'sd0));
    send_word(make_req(REQ_INSERT, 1'b0, 5'd0,  16'sh5555));
    send_word(make_req(REQ_READ,   1'b1, 5'd0,  16'sd0));
    send_word(make_req(REQ_READ,   1'b0, 5'd2,  16'sd0));
    // delete after the tail has no successor
    send_word(make_req(REQ_DELETE, 1'b0, 5'd3,  16'sd0));
    send_word(make_req(REQ_DELETE, 1'b0, 5'd1,  16'sd0));
    send_word(make_req(REQ_DELETE, 1'b1, 5'd0,  16'sd0));
    send_word(make_req(REQ_READ,   1'b0, 5'd1,  16'sd0));
    send_word(make_req(REQ_INSERT, 1'b1, 5'd31, 16'shaaaa));
    send_word(make_req(REQ_NOP,    1'b0, 5'd10, 16'sh5555));
    repeat (4) send_word(make_req(REQ_DELETE, 1'b1, 5'd0, 16'sd0));
  endtask

  // fill the pool until inserts are refused, then empty it again
  task automatic test_fill_and_drain();
    logic head;
    while (free_top != NIL) begin
      head = (list_top == NIL) ? 1'b1 : 1'($urandom_range(0, 1));
      send_word(make_req(REQ_INSERT, head, pick_list_node(), DATA_WIDTH'($urandom())));
    end
    send_word(make_req(REQ_INSERT, 1'b1, 5'd0, 16'sd1));
    send_word(make_req(REQ_INSERT, 1'b0, pick_list_node(), 16'sd2));
    send_word(make_req(REQ_READ, 1'b1, 5'd0, 16'sd0));
    while (list_top != NIL) begin
      send_word(make_req(REQ_DELETE, 1'($urandom_range(0, 1)), pick_list_node(), 16'sd0));
    end
    send_word(make_req(REQ_DELETE, 1'b0, 5'd0, 16'sd0));
  endtask

  // random traffic on a well-formed list, growing and shrinking in epochs
  task automatic test_list_traffic(input int count);
    bit grow;
    int epoch_left;
    grow = 1'b1;
    epoch_left = 0;
    for (int i = 0; i < count; i++) begin
      if (epoch_left == 0) begin
        grow = ~grow;
        epoch_left = $urandom_range(20, 60);
      end
      epoch_left--;
      if (i % 100 == 0) idle_enable = ($urandom_range(0, 3) != 0);
      // pause until all words are back, now and then
      if (i % 300 == 150) wait_drained();
      send_word(rand_request(1'b0, grow));
    end
  endtask

  // links through arbitrary nodes, on or off the list
  task automatic test_stray_links(input int count);
    idle_enable = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_word(rand_request(1'b1, 1'($urandom_range(0, 1))));
    end
  endtask

  // closing traffic with no idle cycles
  task automatic test_back_to_back(input int count);
    idle_enable = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_word(rand_request(1'b0, (i / 40) % 2 == 0));
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : check_results
    alp_res_t want;
    if (!rst && done) begin
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", result));
      end else begin
        want = awaited_words.pop_front();
        check_field("status",      32'(result.status),      32'(want.status));
        check_field("node_index",  32'(result.node_index),  32'(want.node_index));
        check_field("node_data",   32'(result.node_data),   32'(want.node_data));
        check_field("node_next",   32'(result.node_next),   32'(want.node_next));
        check_field("next_is_nil", 32'(result.next_is_nil), 32'(want.next_is_nil));
        check_field("head_index",  32'(result.head_index),  32'(want.head_index));
        check_field("list_empty",  32'(result.list_empty),  32'(want.list_empty));
        check_field("pool_full",   32'(result.pool_full),   32'(want.pool_full));
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no activity for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    reset_pool_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_drain();
    test_list_traffic(1200);
    test_stray_links(80);
    test_back_to_back(480);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/alp_pkg.sv
design/alp_ram.sv
design/array_linked_list_pool.sv
sim/tb_top.sv
